FILE: hdl/rc4_pkg.sv
// Shared types and constants for the RC4 cipher block.
package rc4_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned SBOX_DEPTH        = 256;
  localparam int unsigned SBOX_AW           = 8;
  localparam int unsigned KEY_BYTES_MAX_DEF = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                 we;
    logic [SBOX_AW-1:0]   addr;
    byte_t                data;
  } sbox_wr_t;

endpackage

FILE: hdl/rc4_key_ram.sv
// Key store: one write port, one registered read port.
module rc4_key_ram #(
  parameter int unsigned DEPTH = rc4_pkg::KEY_BYTES_MAX_DEF,
  parameter int unsigned AW    = 8
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  rc4_pkg::byte_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output rc4_pkg::byte_t rdata_o
);

  rc4_pkg::byte_t mem [DEPTH];
  rc4_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rc4_sbox_ram.sv
// S-box permutation memory: one write port, one registered read port.
module rc4_sbox_ram (
  input  logic                          clk_i,
  input  rc4_pkg::sbox_wr_t             wr_i,
  input  logic [rc4_pkg::SBOX_AW-1:0]   raddr_i,
  output rc4_pkg::byte_t                rdata_o
);

  rc4_pkg::byte_t mem [rc4_pkg::SBOX_DEPTH];
  rc4_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rc4_stream_cipher.sv
// RC4 cipher top level: sequencer around the shared S-box and key store memories.
// Key byte: written to the key store while it has room. Last key byte: identity fill of the
// 256 S-box entries, then 256 swap steps on the shared S-box, before the next transfer.
// Keyed data byte: KS_J, KS_SWAP, then KS_OUT registers the result and returns to IDLE
// (one S-box read port, three reads and two writes); a last data byte adds the schedule.
// Unkeyed data byte: result next cycle. Reset clears control state; memories are not cleared.
module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           operation_i,
  input  rc4_pkg::byte_t byte_in_i,
  input  logic           last_of_run_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rc4_pkg::byte_t byte_out_o,
  output logic           end_of_message_o,
  output logic           not_keyed_o
);

  localparam int unsigned KA = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int unsigned CW = $clog2(KEY_BYTES_MAX + 1);
  localparam int unsigned AW = rc4_pkg::SBOX_AW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KS_J, ST_KS_SWAP, ST_KS_OUT,
    ST_FILL, ST_MIX_RD, ST_MIX_ACC, ST_MIX_WA, ST_MIX_WB
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     i_q, j_q, cnt_q, acc_q, t_q;
  rc4_pkg::byte_t    si_q, sj_q, data_q;
  logic              last_q;
  logic [KA-1:0]     kpos_q;
  logic [CW-1:0]     key_count_q;
  logic              keyed_q;
  logic              out_valid_q;
  rc4_pkg::byte_t    out_byte_q;
  logic              out_eom_q, out_nk_q;

  rc4_pkg::sbox_wr_t sbox_wr;
  logic [AW-1:0]     sbox_raddr;
  rc4_pkg::byte_t    sbox_rdata, key_rdata, ks;
  logic              in_xfer, out_xfer, key_we, out_load;
  logic [CW-1:0]     count_eff, klen;
  logic [CW:0]       kpos_nx;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == ST_KS_OUT)
                      || ((state_q == ST_IDLE) && in_xfer
                          && (operation_i == rc4_pkg::OP_DATA) && !keyed_q);

  assign count_eff = keyed_q ? '0 : key_count_q;
  assign key_we    = in_xfer && (operation_i == rc4_pkg::OP_KEY)
                     && (count_eff < CW'(KEY_BYTES_MAX));
  assign klen      = (key_count_q == '0) ? CW'(1) : key_count_q;
  assign kpos_nx   = (CW+1)'(kpos_q) + (CW+1)'(1);

  assign ks = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : sbox_rdata);

  always_comb begin
    sbox_wr    = '0;
    sbox_raddr = cnt_q;
    case (state_q)
      ST_IDLE:    sbox_raddr = AW'(i_q + AW'(1));
      ST_KS_J:    sbox_raddr = AW'(j_q + sbox_rdata);
      ST_KS_SWAP: begin
        sbox_raddr = AW'(si_q + sbox_rdata);
        sbox_wr    = '{we: 1'b1, addr: i_q, data: sbox_rdata};
      end
      ST_KS_OUT:  sbox_wr = '{we: 1'b1, addr: j_q, data: si_q};
      ST_FILL:    sbox_wr = '{we: 1'b1, addr: cnt_q, data: cnt_q};
      ST_MIX_ACC: sbox_raddr = AW'(acc_q + sbox_rdata + key_rdata);
      ST_MIX_WA:  sbox_wr = '{we: 1'b1, addr: cnt_q, data: sbox_rdata};
      ST_MIX_WB:  sbox_wr = '{we: 1'b1, addr: acc_q, data: si_q};
      default:    sbox_raddr = cnt_q;
    endcase
  end

  rc4_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .wr_i    (sbox_wr),
    .raddr_i (sbox_raddr),
    .rdata_o (sbox_rdata)
  );

  rc4_key_ram #(
    .DEPTH (KEY_BYTES_MAX),
    .AW    (KA)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_eff[KA-1:0]),
    .wdata_i (byte_in_i),
    .raddr_i (kpos_q),
    .rdata_o (key_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      t_q         <= '0;
      si_q        <= '0;
      sj_q        <= '0;
      data_q      <= '0;
      last_q      <= 1'b0;
      kpos_q      <= '0;
      key_count_q <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_eom_q   <= 1'b0;
      out_nk_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (operation_i == rc4_pkg::OP_KEY) begin
              keyed_q     <= 1'b0;
              key_count_q <= key_we ? CW'(count_eff + CW'(1)) : count_eff;
              if (last_of_run_i) begin
                cnt_q   <= '0;
                state_q <= ST_FILL;
              end
            end else if (!keyed_q) begin
              out_byte_q  <= byte_in_i;
              out_eom_q   <= last_of_run_i;
              out_nk_q    <= 1'b1;
            end else begin
              data_q  <= byte_in_i;
              last_q  <= last_of_run_i;
              state_q <= ST_KS_J;
            end
          end
        end
        ST_KS_J: begin
          i_q     <= AW'(i_q + AW'(1));
          j_q     <= AW'(j_q + sbox_rdata);
          si_q    <= sbox_rdata;
          state_q <= ST_KS_SWAP;
        end
        ST_KS_SWAP: begin
          sj_q    <= sbox_rdata;
          t_q     <= AW'(si_q + sbox_rdata);
          state_q <= ST_KS_OUT;
        end
        ST_KS_OUT: begin
          out_byte_q  <= data_q ^ ks;
          out_eom_q   <= last_q;
          out_nk_q    <= 1'b0;
          if (last_q) begin
            cnt_q   <= '0;
            state_q <= ST_FILL;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_FILL: begin
          cnt_q <= AW'(cnt_q + AW'(1));
          if (cnt_q == '1) begin
            acc_q   <= '0;
            kpos_q  <= '0;
            state_q <= ST_MIX_RD;
          end
        end
        ST_MIX_RD: state_q <= ST_MIX_ACC;
        ST_MIX_ACC: begin
          si_q    <= sbox_rdata;
          acc_q   <= AW'(acc_q + sbox_rdata + key_rdata);
          kpos_q  <= (kpos_nx >= {1'b0, klen}) ? '0 : KA'(kpos_nx);
          state_q <= ST_MIX_WA;
        end
        ST_MIX_WA: state_q <= ST_MIX_WB;
        ST_MIX_WB: begin
          cnt_q <= AW'(cnt_q + AW'(1));
          if (cnt_q == '1) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MIX_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = out_byte_q;
  assign end_of_message_o = out_eom_q;
  assign not_keyed_o      = out_nk_q;

endmodule

FILE: sim/tb_rc4_stream_cipher.sv
// Testbench for the RC4 cipher block: directed vectors, random key and message traffic.
module tb_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned IDLE_LIMIT   = 8000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 64;

  typedef struct packed {
    rc4_pkg::byte_t data;
    logic           eom;
    logic           nk;
  } cipher_res_t;

  typedef struct packed {
    logic           op;
    rc4_pkg::byte_t b;
    logic           last;
    logic [9:0]     reps;
    logic           typed;
    cipher_res_t    res;
  } stim_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  logic           operation_i;
  rc4_pkg::byte_t byte_in_i;
  logic           last_of_run_i;
  logic           out_valid_o;
  logic           out_stall_i;
  rc4_pkg::byte_t byte_out_o;
  logic           end_of_message_o;
  logic           not_keyed_o;

  rc4_stream_cipher DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .byte_in_i        (byte_in_i),
    .last_of_run_i    (last_of_run_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_out_o       (byte_out_o),
    .end_of_message_o (end_of_message_o),
    .not_keyed_o      (not_keyed_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // cipher model state
  rc4_pkg::byte_t perm [rc4_pkg::SBOX_DEPTH];
  rc4_pkg::byte_t key_mem [rc4_pkg::SBOX_DEPTH];
  logic [8:0]     key_len = '0;
  rc4_pkg::byte_t ix = '0;
  rc4_pkg::byte_t jx = '0;
  bit             have_sched = 1'b0;

  cipher_res_t expected_q [$];
  stim_row_t   dir_rows [$];
  int unsigned items_done = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned calm_left = 0;
  int unsigned noisy_left = 0;
  bit          no_gap = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          draining = 1'b0;

  function automatic void run_ksa();
    rc4_pkg::byte_t acc;
    rc4_pkg::byte_t t;
    int unsigned    kp;
    int unsigned    klen;
    acc = '0;
    kp = 0;
    klen = (key_len == 0) ? 1 : int'(key_len);
    for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) perm[n] = n[7:0];
    for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
      acc = acc + perm[n] + key_mem[kp[7:0]];
      kp++;
      if (kp >= klen) kp = 0;
      t = perm[n];
      perm[n] = perm[acc];
      perm[acc] = t;
    end
    ix = '0;
    jx = '0;
    have_sched = 1'b1;
  endfunction

  // returns 0 for a key byte that is dropped without effect
  function automatic bit cipher_step(input logic op, input rc4_pkg::byte_t b,
                                     input logic last,
                                     output logic produced, output cipher_res_t res);
    rc4_pkg::byte_t t;
    rc4_pkg::byte_t sidx;
    produced = 1'b0;
    res = '0;
    if (op == rc4_pkg::OP_KEY) begin
      if (have_sched) begin
        have_sched = 1'b0;
        key_len = '0;
      end
      if (key_len < rc4_pkg::KEY_BYTES_MAX_DEF) begin
        key_mem[key_len[7:0]] = b;
        key_len++;
      end else if (!last) begin
        return 1'b0;
      end
      if (last) run_ksa();
      return 1'b1;
    end
    produced = 1'b1;
    res.eom = last;
    if (!have_sched) begin
      res.data = b;
      res.nk = 1'b1;
      return 1'b1;
    end
    ix = ix + 8'd1;
    jx = jx + perm[ix];
    t = perm[ix];
    perm[ix] = perm[jx];
    perm[jx] = t;
    sidx = perm[ix] + perm[jx];
    res.data = b ^ perm[sidx];
    res.nk = 1'b0;
    if (last) run_ksa();
    return 1'b1;
  endfunction

  function automatic void add_row(input logic op, input rc4_pkg::byte_t b, input logic last,
                                  input int reps, input logic typed,
                                  input rc4_pkg::byte_t xb,
                                  input logic xeom, input logic xnk);
    stim_row_t rw;
    rw.op = op;
    rw.b = b;
    rw.last = last;
    rw.reps = reps[9:0];
    rw.typed = typed;
    rw.res.data = xb;
    rw.res.eom = xeom;
    rw.res.nk = xnk;
    dir_rows = {dir_rows, rw};
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned pick_gap();
    if (no_gap) return 0;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if (noisy_left != 0) begin
      noisy_left--;
      return ($urandom_range(0, 99) < 45) ? 0 : idle_len();
    end
    if ($urandom_range(0, 99) < 25) calm_left = $urandom_range(10, 60);
    else noisy_left = $urandom_range(20, 150);
    return 0;
  endfunction

  task automatic send_item(input logic op, input rc4_pkg::byte_t b, input logic last,
                           input logic typed, input cipher_res_t typed_res);
    int unsigned gap;
    logic        produced;
    cipher_res_t res;
    bit          counted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    byte_in_i <= b;
    last_of_run_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    counted = cipher_step(op, b, last, produced, res);
    if (produced) expected_q = {expected_q, (typed ? typed_res : res)};
    if (counted) items_done++;
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), k == len - 1,
                1'b0, '0);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_item(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)), k == len - 1,
                1'b0, '0);
  endtask

  task automatic random_sequence();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = $urandom_range(0, 99);
      if (n < 90) send_key($urandom_range(1, 16));
      else if (n < 98) send_key($urandom_range(17, 256));
      else send_key($urandom_range(257, 264));
      repeat ($urandom_range(1, 4)) send_message($urandom_range(1, 24));
    end else if (r < 85) begin
      repeat ($urandom_range(1, 8))
        send_item(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)),
                  logic'($urandom_range(0, 1)), 1'b0, '0);
    end else if (r < 95) begin
      // key loaded in pieces with data slipped in between
      repeat ($urandom_range(1, 4)) begin
        send_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        send_item(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)),
                  logic'($urandom_range(0, 1)), 1'b0, '0);
      end
      send_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    end else begin
      send_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)),
                logic'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic check_result();
    cipher_res_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected transfer: byte_out %h end_of_message %b not_keyed %b",
             byte_out_o, end_of_message_o, not_keyed_o);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (byte_out_o !== want.data) begin
      $error("byte_out: expected %h, got %h", want.data, byte_out_o);
      errors++;
    end
    if (end_of_message_o !== want.eom) begin
      $error("end_of_message: expected %b, got %b", want.eom, end_of_message_o);
      errors++;
    end
    if (not_keyed_o !== want.nk) begin
      $error("not_keyed: expected %b, got %b", want.nk, not_keyed_o);
      errors++;
    end
  endtask

  // receiver: random stalls, one long hold-off on request once a result waits
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_req && !hold_done && out_valid_o) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
        run_left = 0;
      end
      if (draining) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (run_left != 0) begin
        run_left--;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 35) stall_left = idle_len();
        else if ($urandom_range(0, 99) < 5) run_left = $urandom_range(100, 400);
        else run_left = $urandom_range(1, 40);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("rc4_stream_cipher test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned rand_start;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    operation_i <= rc4_pkg::OP_KEY;
    byte_in_i <= '0;
    last_of_run_i <= 1'b0;

    //      op                byte   last reps typed exp   eom   nk
    add_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1, 1'b1, 8'h00, 1'b0, 1'b1);
    add_row(rc4_pkg::OP_DATA, 8'hff, 1'b1, 1, 1'b1, 8'hff, 1'b1, 1'b1);
    add_row(rc4_pkg::OP_KEY,  8'h4b, 1'b0, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'ha5, 1'b0, 1, 1'b1, 8'ha5, 1'b0, 1'b1);
    add_row(rc4_pkg::OP_KEY,  8'h65, 1'b0, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_KEY,  8'h79, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h50, 1'b0, 1, 1'b1, 8'hbb, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h6c, 1'b0, 1, 1'b1, 8'hf3, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h61, 1'b0, 1, 1'b1, 8'h16, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h69, 1'b0, 1, 1'b1, 8'he8, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h6e, 1'b0, 1, 1'b1, 8'hd9, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h74, 1'b0, 1, 1'b1, 8'h40, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h65, 1'b0, 1, 1'b1, 8'haf, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h78, 1'b0, 1, 1'b1, 8'h0a, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h74, 1'b1, 1, 1'b1, 8'hd3, 1'b1, 1'b0);
    // keystream restarts after the message end
    add_row(rc4_pkg::OP_DATA, 8'h50, 1'b0, 1, 1'b1, 8'hbb, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'hff, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    // new key while keyed
    add_row(rc4_pkg::OP_KEY,  8'hff, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h7e, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    // full-length key, then an over-long one whose last-marked byte is dropped
    add_row(rc4_pkg::OP_KEY,  8'h00, 1'b1, 256, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h3c, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_KEY,  8'h80, 1'b1, 300, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(rc4_pkg::OP_DATA, 8'h00, 1'b1, 1, 1'b0, 8'h00, 1'b0, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int k = 0; k < int'(row.reps); k++)
        send_item(row.op, row.b + k[7:0], row.last && (k == int'(row.reps) - 1),
                  row.typed, row.res);
    end

    // back-pressure: receiver holds off while data keeps coming
    send_key(8);
    no_gap = 1'b1;
    hold_req = 1'b1;
    send_message(120);
    no_gap = 1'b0;

    rand_start = items_done;
    while (items_done - rand_start < RANDOM_ITEMS) random_sequence();

    in_valid_i <= 1'b0;
    draining = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("rc4_stream_cipher test passed");
    end else begin
      $display("rc4_stream_cipher test failed");
    end
    $finish;
  end

endmodule
